@@ design/depth_background_max_remap_unit_macros.svh @@
// Assertion macros for the depth background design.
// They sample on clock and are switched off while reset is high.
`ifndef DEPTH_BACKGROUND_MAX_REMAP_UNIT_MACROS_SVH
`define DEPTH_BACKGROUND_MAX_REMAP_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBMR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBMR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/dbmr_pkg.sv @@
`timescale 1ns / 1ps

package dbmr_pkg;

   localparam int DEPTH_W = 16;
   localparam int INDEX_W = 19;
   localparam int LEVEL_W = 8;
   localparam int NUM_W = DEPTH_W + LEVEL_W;

   localparam int PIXEL_COUNT_DEF = 307200;

   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES = LEVEL_W / DIV_STEPS_PER_STAGE;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;

   localparam logic [CSR_INDEX_W-1:0] REG_NEAR_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FAR_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_UPDATE_MARGIN = 2'd2;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } store_state_type;

   typedef struct packed {
      logic [NUM_W-1:0]   rem;
      logic [DEPTH_W-1:0] span;
      logic [LEVEL_W-1:0] quo;
   } div_data_type;

endpackage

@@ design/depth_background_max_remap_unit.sv @@
`timescale 1ns / 1ps
// Per-pixel maximum-hold depth background with an 8-bit remap. One depth transfer is taken
// per clock while the result side is ready, and one level transfer comes out for each. The
// pipeline holds the background store read and update, a register that forms the remap
// numerator and span, and four restoring divider stages of two quotient bits each.
// The store is a single memory with one read and one write port; a sample that hits the same
// pixel as the one just ahead of it is served from a bypass, so back-to-back updates of one
// pixel are exact. After reset the store is swept to zero, one entry per cycle, through all
// PIXEL_COUNT entries, and req_ready is low until that sweep ends; register writes are taken
// throughout. Register writes are expected only while no transfer is in flight.

module depth_background_max_remap_unit #(
   parameter int PIXEL_COUNT = dbmr_pkg::PIXEL_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [dbmr_pkg::DEPTH_W-1:0]    req_depth_sample,
   input  logic [dbmr_pkg::INDEX_W-1:0]    req_pixel_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [dbmr_pkg::LEVEL_W-1:0]    rsp_background_level,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dbmr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dbmr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dbmr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import dbmr_pkg::*;

   logic [DEPTH_W-1:0] near_limit_ff;
   logic [DEPTH_W-1:0] far_limit_ff;
   logic [DEPTH_W-1:0] update_margin_ff;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic csr_write;

   logic store_valid;
   logic store_ready;
   logic [DEPTH_W-1:0] store_bg;

   logic div_valid [DIV_STAGES+1];
   logic div_ready [DIV_STAGES+1];
   div_data_type div_data [DIV_STAGES+1];

   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_limit_ff <= '0;
         far_limit_ff <= '1;
         update_margin_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_NEAR_LIMIT: near_limit_ff <= csr_pwdata[DEPTH_W-1:0];
            REG_FAR_LIMIT: far_limit_ff <= csr_pwdata[DEPTH_W-1:0];
            REG_UPDATE_MARGIN: update_margin_ff <= csr_pwdata[DEPTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_NEAR_LIMIT: csr_prdata = CSR_DATA_W'(near_limit_ff);
         REG_FAR_LIMIT: csr_prdata = CSR_DATA_W'(far_limit_ff);
         REG_UPDATE_MARGIN: csr_prdata = CSR_DATA_W'(update_margin_ff);
         default: csr_prdata = '0;
      endcase
   end

   dbmr_bg_store #(
      .PIXEL_COUNT(PIXEL_COUNT)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .depth_sample (req_depth_sample),
      .pixel_index  (req_pixel_index),
      .update_margin(update_margin_ff),
      .out_valid    (store_valid),
      .out_ready    (store_ready),
      .out_bg       (store_bg)
   );

   dbmr_remap_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (store_valid),
      .in_ready  (store_ready),
      .bg        (store_bg),
      .near_limit(near_limit_ff),
      .far_limit (far_limit_ff),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      dbmr_div_stage #(
         .STEP_HI(LEVEL_W - 1 - s * DIV_STEPS_PER_STAGE)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .in_valid (div_valid[s]),
         .in_ready (div_ready[s]),
         .in_data  (div_data[s]),
         .out_valid(div_valid[s+1]),
         .out_ready(div_ready[s+1]),
         .out_data (div_data[s+1])
      );
   end

   assign rsp_valid = div_valid[DIV_STAGES];
   assign div_ready[DIV_STAGES] = rsp_ready;
   assign rsp_background_level = div_data[DIV_STAGES].quo;

endmodule

@@ design/dbmr_bg_store.sv @@
`timescale 1ns / 1ps
`include "depth_background_max_remap_unit_macros.svh"

module dbmr_bg_store #(
   parameter int PIXEL_COUNT = dbmr_pkg::PIXEL_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [dbmr_pkg::DEPTH_W-1:0] depth_sample,
   input  logic [dbmr_pkg::INDEX_W-1:0] pixel_index,
   input  logic [dbmr_pkg::DEPTH_W-1:0] update_margin,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [dbmr_pkg::DEPTH_W-1:0] out_bg
);
   import dbmr_pkg::*;

   localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   store_state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic clearing;
   logic clr_last;

   logic [DEPTH_W-1:0] bg_mem_ff [PIXEL_COUNT];
   logic [DEPTH_W-1:0] rd_data_ff;

   logic a_valid_ff;
   logic a_in_range_ff;
   logic [ADDR_W-1:0] a_addr_ff;
   logic [DEPTH_W-1:0] a_sample_ff;
   logic byp_hit_ff;
   logic [DEPTH_W-1:0] byp_data_ff;

   logic a_ready;
   logic accept;
   logic in_range;
   logic [ADDR_W-1:0] in_addr;
   logic [DEPTH_W-1:0] bg_cur;
   logic upd;
   logic a_write;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DEPTH_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_cnt_in = clr_cnt_ff;
      clearing = 1'b0;
      clr_last = (clr_cnt_ff == ADDR_W'(PIXEL_COUNT - 1));
      case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
            if (clr_last) begin
               clr_cnt_in = '0;
               state_in = ST_RUN;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_RUN: begin
            clr_cnt_in = '0;
         end
         default: begin
            state_in = ST_CLEAR;
            clr_cnt_in = '0;
         end
      endcase
   end

   assign a_ready = !a_valid_ff || out_ready;
   assign req_ready = a_ready && (state_ff == ST_RUN);
   assign accept = req_valid && req_ready;
   assign in_range = 32'(pixel_index) < 32'(PIXEL_COUNT);
   assign in_addr = ADDR_W'(pixel_index);

   always_comb begin
      if (!a_in_range_ff) begin
         bg_cur = '0;
      end else if (byp_hit_ff) begin
         bg_cur = byp_data_ff;
      end else begin
         bg_cur = rd_data_ff;
      end
      upd = a_in_range_ff && (a_sample_ff != '0) &&
            ({1'b0, a_sample_ff} > ({1'b0, bg_cur} + {1'b0, update_margin}));
   end

   assign a_write = a_valid_ff && out_ready && a_in_range_ff && upd;
   assign wr_en = clearing || a_write;
   assign wr_addr = clearing ? clr_cnt_ff : a_addr_ff;
   assign wr_data = clearing ? '0 : a_sample_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bg_mem_ff[wr_addr] <= wr_data;
      end
      if (accept && in_range) begin
         rd_data_ff <= bg_mem_ff[in_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         byp_hit_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= accept;
         byp_hit_ff <= accept && a_write && (a_addr_ff == in_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_in_range_ff <= in_range;
         a_addr_ff <= in_addr;
         a_sample_ff <= depth_sample;
         byp_data_ff <= a_sample_ff;
      end
   end

   assign out_valid = a_valid_ff;
   assign out_bg = upd ? a_sample_ff : bg_cur;

   `DBMR_ASSERT_NOW(a_no_item_in_clear, state_ff == ST_CLEAR, !a_valid_ff, "item during clear")
   `DBMR_ASSERT_NOW(a_cnt_idle_in_run, state_ff == ST_RUN, clr_cnt_ff == '0, "clear count left")
   `DBMR_ASSERT_NOW(a_bypass_needs_item, byp_hit_ff, a_valid_ff, "bypass without item")
   `DBMR_ASSERT_NEXT(a_stall_holds, a_valid_ff && !out_ready,
                     a_valid_ff && $stable(a_sample_ff) && $stable(a_addr_ff),
                     "stalled sample lost")

endmodule

@@ design/dbmr_remap_prep.sv @@
`timescale 1ns / 1ps

module dbmr_remap_prep (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [dbmr_pkg::DEPTH_W-1:0] bg,
   input  logic [dbmr_pkg::DEPTH_W-1:0] near_limit,
   input  logic [dbmr_pkg::DEPTH_W-1:0] far_limit,
   output logic                         out_valid,
   input  logic                         out_ready,
   output dbmr_pkg::div_data_type       out_data
);
   import dbmr_pkg::*;

   logic valid_ff;
   div_data_type data_ff, data_in;
   logic out_of_window;
   logic [DEPTH_W-1:0] delta;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      out_of_window = (bg == '0) || (bg < near_limit) || (bg > far_limit) ||
                      (far_limit == near_limit);
      delta = bg - near_limit;
      if (out_of_window) begin
         data_in.rem = '0;
         data_in.span = '1;
      end else begin
         data_in.rem = {delta, LEVEL_W'(0)} - NUM_W'(delta);
         data_in.span = far_limit - near_limit;
      end
      data_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

@@ design/dbmr_div_stage.sv @@
`timescale 1ns / 1ps

module dbmr_div_stage #(
   parameter int STEP_HI = dbmr_pkg::LEVEL_W - 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  dbmr_pkg::div_data_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output dbmr_pkg::div_data_type out_data
);
   import dbmr_pkg::*;

   logic valid_ff;
   div_data_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      logic [NUM_W-1:0] divisor;
      data_in = in_data;
      for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
         divisor = NUM_W'(data_in.span) << (STEP_HI - j);
         if (data_in.rem >= divisor) begin
            data_in.rem = data_in.rem - divisor;
            data_in.quo[STEP_HI - j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import dbmr_pkg::*;

   localparam int PIXELS = PIXEL_COUNT_DEF;
   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int POOL_SIZE = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [INDEX_W-1:0] pixel;
   } depth_sample_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [DEPTH_W-1:0] req_depth_sample = '0;
   logic [INDEX_W-1:0] req_pixel_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [LEVEL_W-1:0] rsp_background_level;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   depth_sample_t pending_samples[$];
   logic [LEVEL_W-1:0] expected_levels[$];
   logic [DEPTH_W-1:0] background_copy [PIXELS];
   logic [INDEX_W-1:0] pixel_pool [POOL_SIZE];
   int unsigned near_cfg;
   int unsigned far_cfg;
   int unsigned margin_cfg;
   int errors = 0;
   int cycle_count = 0;
   bit steady = 1'b0;

   depth_background_max_remap_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_depth_sample(req_depth_sample),
      .req_pixel_index(req_pixel_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_background_level(rsp_background_level),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   function automatic logic [LEVEL_W-1:0] remap_background(input logic [DEPTH_W-1:0] bg);
      int unsigned level;
      int unsigned span;
      level = bg;
      if (level == 0 || level < near_cfg || level > far_cfg) begin
         return '0;
      end
      span = far_cfg - near_cfg;
      if (span == 0) begin
         return '0;
      end
      return LEVEL_W'(((level - near_cfg) * 255) / span);
   endfunction

   task automatic update_background(input logic [DEPTH_W-1:0] depth,
                                    input logic [INDEX_W-1:0] pixel);
      logic [DEPTH_W-1:0] bg;
      int unsigned sample;
      bg = '0;
      sample = depth;
      if (pixel < PIXELS) begin
         bg = background_copy[pixel];
         if (sample != 0 && sample > int'(bg) + margin_cfg) begin
            bg = depth;
            background_copy[pixel] = depth;
         end
      end
      expected_levels.push_back(remap_background(bg));
   endtask

   task automatic report_mismatch(input string what, input int expected_value,
                                  input int actual_value);
      $display("tb: %s mismatch at cycle %0d: expected %0d, got %0d",
               what, cycle_count, expected_value, actual_value);
      errors++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin : drive_samples
      depth_sample_t next_sample;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            update_background(req_depth_sample, req_pixel_index);
         end
         if (!req_valid || req_ready) begin
            if (pending_samples.size() > 0 && (steady || $urandom_range(99) >= 28)) begin
               next_sample = pending_samples.pop_front();
               req_valid <= 1'b1;
               req_depth_sample <= next_sample.depth;
               req_pixel_index <= next_sample.pixel;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 28);
   end

   always @(posedge clock) begin : watch_levels
      logic [LEVEL_W-1:0] expected_level;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_levels.size() == 0) begin
            report_mismatch("unexpected level transfer", -1, rsp_background_level);
         end else begin
            expected_level = expected_levels.pop_front();
            if (rsp_background_level !== expected_level) begin
               report_mismatch("background_level", expected_level, rsp_background_level);
            end
         end
      end
   end

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [DEPTH_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_NEAR_LIMIT: near_cfg = value;
         REG_FAR_LIMIT: far_cfg = value;
         REG_UPDATE_MARGIN: margin_cfg = value;
         default: ;
      endcase
   endtask

   task automatic set_window(input int unsigned near_value, input int unsigned far_value,
                             input int unsigned margin_value);
      write_register(REG_NEAR_LIMIT, DEPTH_W'(near_value));
      write_register(REG_FAR_LIMIT, DEPTH_W'(far_value));
      write_register(REG_UPDATE_MARGIN, DEPTH_W'(margin_value));
   endtask

   task automatic queue_sample(input int unsigned depth, input int unsigned pixel);
      pending_samples.push_back('{depth: DEPTH_W'(depth), pixel: INDEX_W'(pixel)});
   endtask

   task automatic wait_for_idle();
      do begin
         @(posedge clock);
      end while (pending_samples.size() > 0 || req_valid || expected_levels.size() > 0);
   endtask

   task automatic queue_random_samples(input int count);
      int unsigned pixel;
      int depth;
      int pick;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pixel_pool[i] = INDEX_W'($urandom_range(PIXELS - 1, 0));
      end
      pixel_pool[0] = '0;
      pixel_pool[1] = INDEX_W'(PIXELS - 1);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            pixel = pixel_pool[$urandom_range(POOL_SIZE - 1, 0)];
         end else if (pick < 90) begin
            pixel = $urandom_range(PIXELS - 1, 0);
         end else begin
            pixel = $urandom_range((1 << INDEX_W) - 1, PIXELS);
         end
         pick = $urandom_range(99);
         if (pick < 12) begin
            depth = 0;
         end else if (pick < 45 && pixel < PIXELS) begin
            depth = int'(background_copy[pixel]) + int'(margin_cfg) + $urandom_range(3) - 1;
         end else if (pick < 75) begin
            depth = $urandom_range(far_cfg, near_cfg) + $urandom_range(4) - 2;
         end else begin
            depth = $urandom_range(65535);
         end
         if (depth < 0) begin
            depth = 0;
         end else if (depth > 65535) begin
            depth = 65535;
         end
         queue_sample(depth, pixel);
      end
      wait_for_idle();
   endtask

   initial begin : run_test
      int unsigned near_value;
      int unsigned far_value;
      foreach (background_copy[i]) begin
         background_copy[i] = '0;
      end
      near_cfg = 0;
      far_cfg = 65535;
      margin_cfg = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_window(0, 65535, 0);
      write_register(REG_UNUSED, 16'h1234);
      queue_sample(0, 0);
      queue_sample(65535, PIXELS - 1);
      queue_sample(1, 0);
      queue_sample(300, 0);
      queue_sample(200, 0);
      queue_sample(65535, PIXELS);
      queue_sample(65535, (1 << INDEX_W) - 1);
      queue_sample(1000, 5);
      queue_sample(2000, 5);
      queue_sample(1500, 5);
      queue_sample(0, 5);
      wait_for_idle();

      set_window(1000, 1000, 0);
      queue_sample(1000, 7);
      queue_sample(500, 8);
      wait_for_idle();

      set_window(5000, 100, 0);
      queue_sample(3000, 13);
      queue_sample(0, 5);
      wait_for_idle();

      set_window(2000, 3000, 500);
      queue_sample(2400, 9);
      queue_sample(2800, 9);
      queue_sample(2950, 9);
      queue_sample(1500, 10);
      queue_sample(4000, 11);
      queue_sample(3000, 14);
      queue_sample(2000, 15);
      wait_for_idle();

      set_window(0, 65535, 65535);
      queue_sample(65535, 12);
      wait_for_idle();

      set_window(0, 65535, 0);
      queue_random_samples(250);

      near_value = $urandom_range(30000);
      set_window(near_value, near_value + $urandom_range(35535, 1), $urandom_range(300));
      queue_random_samples(250);

      near_value = $urandom_range(65535);
      set_window(near_value, near_value, $urandom_range(50));
      queue_random_samples(250);

      far_value = $urandom_range(30000);
      set_window(far_value + $urandom_range(35535, 1), far_value, 0);
      queue_random_samples(250);

      set_window(0, 65535, 65535);
      queue_random_samples(200);

      steady = 1'b1;
      near_value = $urandom_range(20000);
      set_window(near_value, near_value + $urandom_range(45535, 1000), 0);
      queue_random_samples(300);
      steady = 1'b0;

      near_value = $urandom_range(60000);
      set_window(near_value, near_value + $urandom_range(10, 1), $urandom_range(3));
      queue_random_samples(250);

      near_value = $urandom_range(65535);
      far_value = $urandom_range(65535);
      set_window(near_value, far_value, $urandom_range(65535));
      queue_random_samples(250);

      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
